[rtl/core/bgc_pkg.sv]
package bgc_pkg;

	localparam int unsigned PaddrW = 4;
	localparam int unsigned PdataW = 32;

	localparam logic [15:0] AuthTimeoutRst  = 16'd10000;
	localparam logic [15:0] RejectAlertRst  = 16'd3000;
	localparam logic [15:0] AutoCloseRst    = 16'd3000;
	localparam logic [15:0] TelemPeriodRst  = 16'd5000;

	typedef enum logic [1:0] {
		REG_AUTH_TIMEOUT = 2'd0,
		REG_REJECT_ALERT = 2'd1,
		REG_AUTO_CLOSE   = 2'd2,
		REG_TELEM_PERIOD = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_WAIT    = 3'd1,
		ST_DENIED  = 3'd2,
		ST_OPENING = 3'd3,
		ST_OPEN    = 3'd4,
		ST_DELAY   = 3'd5,
		ST_CLOSING = 3'd6
	} gate_state_t;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_REPLY = 2'd1,
		ACT_CMD   = 2'd2
	} action_t;

	localparam logic [1:0] REPLY_ALLOW = 2'd0;
	localparam logic [1:0] REPLY_DENY  = 2'd1;

	localparam logic [2:0] CMD_OPEN     = 3'd0;
	localparam logic [2:0] CMD_CLOSE    = 3'd1;
	localparam logic [2:0] CMD_AUTO_ON  = 3'd2;
	localparam logic [2:0] CMD_AUTO_OFF = 3'd3;

	localparam logic [1:0] PULSE_NONE  = 2'd0;
	localparam logic [1:0] PULSE_OPEN  = 2'd1;
	localparam logic [1:0] PULSE_CLOSE = 2'd2;

	localparam logic [1:0] LIGHT_RED    = 2'd0;
	localparam logic [1:0] LIGHT_WAIT   = 2'd1;
	localparam logic [1:0] LIGHT_MOVING = 2'd2;
	localparam logic [1:0] LIGHT_GREEN  = 2'd3;

	localparam logic [3:0] EV_NONE      = 4'd0;
	localparam logic [3:0] EV_ENTRY_REQ = 4'd1;
	localparam logic [3:0] EV_DENIED    = 4'd2;
	localparam logic [3:0] EV_OPENING   = 4'd3;
	localparam logic [3:0] EV_OPEN      = 4'd4;
	localparam logic [3:0] EV_CLOSING   = 4'd5;
	localparam logic [3:0] EV_CLOSED    = 4'd6;
	localparam logic [3:0] EV_CANCELLED = 4'd7;
	localparam logic [3:0] EV_AUTH_TO   = 4'd8;
	localparam logic [3:0] EV_CLEARED   = 4'd9;
	localparam logic [3:0] EV_REOPEN    = 4'd10;

	typedef struct packed {
		logic [15:0] auth_wait_ms;
		logic [15:0] reject_alert_ms;
		logic [15:0] auto_close_ms;
		logic [15:0] telemetry_period_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now_ms;
		logic        vehicle_arrived;
		logic        vehicle_gone;
		logic        vehicle_present;
		logic        fully_open;
		logic        fully_closed;
		logic [1:0]  response_kind;
		logic [2:0]  command_kind;
	} item_t;

	typedef struct packed {
		gate_state_t gate_state;
		logic [31:0] entry_ms;
		logic [31:0] last_report_ms;
		logic        auto_open;
		logic [1:0]  light_held;
	} gate_regs_t;

	typedef struct packed {
		logic [2:0] state_now;
		logic [1:0] barrier_command;
		logic [1:0] light_mode;
		logic [3:0] first_event;
		logic [3:0] second_event;
		logic       telemetry_due;
		logic       auto_open_now;
	} result_t;

endpackage

[rtl/core/barrier_gate_controller.sv]
// channel | dir | handshake            | payload
// --------+-----+----------------------+---------------------------------------------
// in      | in  | in_valid / in_ready  | action, now_ms, sensor and barrier flags,
//         |     |                      | response_kind, command_kind
// out     | out | out_valid/out_ready  | state_now, barrier_command, light_mode,
//         |     |                      | first_event, second_event, telemetry_due,
//         |     |                      | auto_open_now
// cfg     | in  | APB psel/penable     | four 16-bit timing registers at 0x0..0xC
//
// One request per cycle while out_ready is high; out_valid flags the result register.
// The input register feeds the step logic, which updates the gate state and
// loads the result register in the same edge, so the next request sees fresh state.
// A stalled output holds the result; one more request waits in the input register.
// arst_n clears the gate state, timestamps, auto-open flag and light; the timing
// registers return to their defaults.
module barrier_gate_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bgc_pkg::PaddrW-1:0]  paddr,
	input  logic [bgc_pkg::PdataW-1:0]  pwdata,
	output logic [bgc_pkg::PdataW-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [31:0]                 now_ms,
	input  logic                        vehicle_arrived,
	input  logic                        vehicle_gone,
	input  logic                        vehicle_present,
	input  logic                        fully_open,
	input  logic                        fully_closed,
	input  logic [1:0]                  response_kind,
	input  logic [2:0]                  command_kind,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  state_now,
	output logic [1:0]                  barrier_command,
	output logic [1:0]                  light_mode,
	output logic [3:0]                  first_event,
	output logic [3:0]                  second_event,
	output logic                        telemetry_due,
	output logic                        auto_open_now
);

	bgc_pkg::cfg_t       cfg;
	bgc_pkg::item_t      item_s1;
	logic                vld_s1;
	bgc_pkg::result_t    res_s2;
	logic                vld_s2;
	bgc_pkg::gate_regs_t gate_q;
	bgc_pkg::gate_regs_t gate_nxt;
	bgc_pkg::result_t    res;
	logic                adv;

	bgc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bgc_step u_step (
		.item (item_s1),
		.cur  (gate_q),
		.cfg  (cfg),
		.nxt  (gate_nxt),
		.res  (res)
	);

	assign adv      = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action          <= action;
			item_s1.now_ms          <= now_ms;
			item_s1.vehicle_arrived <= vehicle_arrived;
			item_s1.vehicle_gone    <= vehicle_gone;
			item_s1.vehicle_present <= vehicle_present;
			item_s1.fully_open      <= fully_open;
			item_s1.fully_closed    <= fully_closed;
			item_s1.response_kind   <= response_kind;
			item_s1.command_kind    <= command_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= '0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv)
				gate_q <= gate_nxt;
			if (!vld_s2 || out_ready)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	assign out_valid       = vld_s2;
	assign state_now       = res_s2.state_now;
	assign barrier_command = res_s2.barrier_command;
	assign light_mode      = res_s2.light_mode;
	assign first_event     = res_s2.first_event;
	assign second_event    = res_s2.second_event;
	assign telemetry_due   = res_s2.telemetry_due;
	assign auto_open_now   = res_s2.auto_open_now;

endmodule

[rtl/core/bgc_cfg_regs.sv]
module bgc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bgc_pkg::PaddrW-1:0]  paddr,
	input  logic [bgc_pkg::PdataW-1:0]  pwdata,
	output logic [bgc_pkg::PdataW-1:0]  prdata,
	output logic                        pready,
	output bgc_pkg::cfg_t               cfg
);

	bgc_pkg::cfg_t    cfg_q;
	bgc_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = bgc_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auth_wait_ms        <= bgc_pkg::AuthTimeoutRst;
			cfg_q.reject_alert_ms     <= bgc_pkg::RejectAlertRst;
			cfg_q.auto_close_ms       <= bgc_pkg::AutoCloseRst;
			cfg_q.telemetry_period_ms <= bgc_pkg::TelemPeriodRst;
		end else if (wr_en) begin
			unique case (idx)
				bgc_pkg::REG_AUTH_TIMEOUT: cfg_q.auth_wait_ms        <= pwdata[15:0];
				bgc_pkg::REG_REJECT_ALERT: cfg_q.reject_alert_ms     <= pwdata[15:0];
				bgc_pkg::REG_AUTO_CLOSE:   cfg_q.auto_close_ms       <= pwdata[15:0];
				bgc_pkg::REG_TELEM_PERIOD: cfg_q.telemetry_period_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			bgc_pkg::REG_AUTH_TIMEOUT: prdata = {16'd0, cfg_q.auth_wait_ms};
			bgc_pkg::REG_REJECT_ALERT: prdata = {16'd0, cfg_q.reject_alert_ms};
			bgc_pkg::REG_AUTO_CLOSE:   prdata = {16'd0, cfg_q.auto_close_ms};
			bgc_pkg::REG_TELEM_PERIOD: prdata = {16'd0, cfg_q.telemetry_period_ms};
			default:                   prdata = '0;
		endcase
	end

endmodule

[rtl/core/bgc_step.sv]
module bgc_step (
	input  bgc_pkg::item_t      item,
	input  bgc_pkg::gate_regs_t cur,
	input  bgc_pkg::cfg_t       cfg,
	output bgc_pkg::gate_regs_t nxt,
	output bgc_pkg::result_t    res
);

	logic                 enter_en;
	bgc_pkg::gate_state_t enter_code;
	logic [3:0]           ev_pre;
	logic [3:0]           ev_enter;
	logic [1:0]           pulse;
	logic                 due;
	logic [31:0]          age;
	logic [31:0]          rep_age;

	assign age     = item.now_ms - cur.entry_ms;
	assign rep_age = item.now_ms - cur.last_report_ms;

	always_comb begin
		nxt        = cur;
		enter_en   = 1'b0;
		enter_code = bgc_pkg::ST_IDLE;
		ev_pre     = bgc_pkg::EV_NONE;
		ev_enter   = bgc_pkg::EV_NONE;
		pulse      = bgc_pkg::PULSE_NONE;
		due        = 1'b0;

		unique case (item.action)
			bgc_pkg::ACT_TICK: begin
				unique case (cur.gate_state)
					bgc_pkg::ST_IDLE: begin
						if (item.vehicle_arrived) begin
							enter_en   = 1'b1;
							enter_code = cur.auto_open ? bgc_pkg::ST_OPENING : bgc_pkg::ST_WAIT;
						end
					end
					bgc_pkg::ST_WAIT: begin
						if (item.vehicle_gone) begin
							ev_pre   = bgc_pkg::EV_CANCELLED;
							enter_en = 1'b1;
						end else if (age >= {16'd0, cfg.auth_wait_ms}) begin
							ev_pre   = bgc_pkg::EV_AUTH_TO;
							enter_en = 1'b1;
						end
					end
					bgc_pkg::ST_DENIED: begin
						if (age >= {16'd0, cfg.reject_alert_ms})
							nxt.light_held = bgc_pkg::LIGHT_RED;
						if (item.vehicle_gone)
							enter_en = 1'b1;
					end
					bgc_pkg::ST_OPENING: begin
						if (item.fully_open) begin
							enter_en   = 1'b1;
							enter_code = bgc_pkg::ST_OPEN;
						end
					end
					bgc_pkg::ST_OPEN: begin
						if (item.vehicle_gone) begin
							ev_pre     = bgc_pkg::EV_CLEARED;
							enter_en   = 1'b1;
							enter_code = bgc_pkg::ST_DELAY;
						end
					end
					bgc_pkg::ST_DELAY: begin
						if (item.vehicle_present) begin
							enter_en   = 1'b1;
							enter_code = bgc_pkg::ST_OPEN;
						end else if (age >= {16'd0, cfg.auto_close_ms}) begin
							enter_en   = 1'b1;
							enter_code = bgc_pkg::ST_CLOSING;
						end
					end
					bgc_pkg::ST_CLOSING: begin
						if (item.vehicle_present) begin
							ev_pre     = bgc_pkg::EV_REOPEN;
							enter_en   = 1'b1;
							enter_code = bgc_pkg::ST_OPENING;
						end else if (item.fully_closed) begin
							ev_pre   = bgc_pkg::EV_CLOSED;
							enter_en = 1'b1;
						end
					end
					default: ;
				endcase
			end
			bgc_pkg::ACT_REPLY: begin
				if (cur.gate_state == bgc_pkg::ST_WAIT || cur.gate_state == bgc_pkg::ST_DENIED) begin
					if (item.response_kind == bgc_pkg::REPLY_ALLOW) begin
						enter_en   = 1'b1;
						enter_code = bgc_pkg::ST_OPENING;
					end else if (item.response_kind == bgc_pkg::REPLY_DENY) begin
						enter_en   = 1'b1;
						enter_code = bgc_pkg::ST_DENIED;
					end
				end
			end
			bgc_pkg::ACT_CMD: begin
				unique case (item.command_kind)
					bgc_pkg::CMD_OPEN: begin
						enter_en   = 1'b1;
						enter_code = bgc_pkg::ST_OPENING;
					end
					bgc_pkg::CMD_CLOSE: begin
						enter_en   = 1'b1;
						enter_code = bgc_pkg::ST_CLOSING;
					end
					bgc_pkg::CMD_AUTO_ON:  nxt.auto_open = 1'b1;
					bgc_pkg::CMD_AUTO_OFF: nxt.auto_open = 1'b0;
					default: ;
				endcase
			end
			default: ;
		endcase

		// state entry actions; these override the denied light fallback
		if (enter_en) begin
			nxt.gate_state = enter_code;
			nxt.entry_ms   = item.now_ms;
			unique case (enter_code)
				bgc_pkg::ST_IDLE: begin
					pulse          = bgc_pkg::PULSE_CLOSE;
					nxt.light_held = bgc_pkg::LIGHT_RED;
				end
				bgc_pkg::ST_WAIT: begin
					nxt.light_held = bgc_pkg::LIGHT_WAIT;
					ev_enter       = bgc_pkg::EV_ENTRY_REQ;
				end
				bgc_pkg::ST_DENIED: begin
					pulse          = bgc_pkg::PULSE_CLOSE;
					nxt.light_held = bgc_pkg::LIGHT_MOVING;
					ev_enter       = bgc_pkg::EV_DENIED;
				end
				bgc_pkg::ST_OPENING: begin
					pulse          = bgc_pkg::PULSE_OPEN;
					nxt.light_held = bgc_pkg::LIGHT_MOVING;
					ev_enter       = bgc_pkg::EV_OPENING;
				end
				bgc_pkg::ST_OPEN: begin
					nxt.light_held = bgc_pkg::LIGHT_GREEN;
					ev_enter       = bgc_pkg::EV_OPEN;
				end
				bgc_pkg::ST_CLOSING: begin
					pulse          = bgc_pkg::PULSE_CLOSE;
					nxt.light_held = bgc_pkg::LIGHT_MOVING;
					ev_enter       = bgc_pkg::EV_CLOSING;
				end
				default: ;
			endcase
		end

		if (item.action == bgc_pkg::ACT_TICK && rep_age >= {16'd0, cfg.telemetry_period_ms}) begin
			nxt.last_report_ms = item.now_ms;
			due                = 1'b1;
		end

		res.state_now       = nxt.gate_state;
		res.barrier_command = pulse;
		res.light_mode      = nxt.light_held;
		res.telemetry_due   = due;
		res.auto_open_now   = nxt.auto_open;
		if (ev_pre != bgc_pkg::EV_NONE) begin
			res.first_event  = ev_pre;
			res.second_event = ev_enter;
		end else begin
			res.first_event  = ev_enter;
			res.second_event = bgc_pkg::EV_NONE;
		end
	end

endmodule
